@@ rtl/core/ptbl_pkg.sv @@
`default_nettype none

package ptbl_pkg;

  localparam int OPCODE_BITS   = 2;
  localparam int TYPE_BITS     = 3;
  // wide enough to compare a type code against a type count of 64
  localparam int TYPE_EXT_BITS = 7;
  localparam int STATUS_BITS   = 3;
  localparam int MAX_RESULTS   = 64;
  localparam int WALK_CNT_BITS = 6;

  localparam logic [OPCODE_BITS-1:0] OP_CLEAR = 2'd0;
  localparam logic [OPCODE_BITS-1:0] OP_ADD   = 2'd1;
  localparam logic [OPCODE_BITS-1:0] OP_WALK  = 2'd2;

  localparam logic [STATUS_BITS-1:0] ST_CLEARED        = 3'd0;
  localparam logic [STATUS_BITS-1:0] ST_HEAD_FILLED    = 3'd1;
  localparam logic [STATUS_BITS-1:0] ST_TAIL_EXTENDED  = 3'd2;
  localparam logic [STATUS_BITS-1:0] ST_ENTRY_LINKED   = 3'd3;
  localparam logic [STATUS_BITS-1:0] ST_ZERO_IGNORED   = 3'd4;
  localparam logic [STATUS_BITS-1:0] ST_POOL_FULL      = 3'd5;
  localparam logic [STATUS_BITS-1:0] ST_RANGE_OVERFLOW = 3'd6;
  localparam logic [STATUS_BITS-1:0] ST_RANGE_LISTED   = 3'd7;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HEAD,
    S_ADD,
    S_LINK,
    S_WALK,
    S_WALK_RD,
    S_EMIT
  } state_t;

endpackage

`default_nettype wire

@@ rtl/core/per_type_batch_list_builder.sv @@
// Channel | Direction | Handshake            | Payload
// in      | input     | in_valid / in_ready   | opcode, list_type, first_index, instance_count
// out     | output    | out_valid / out_ready | status, range_first, range_end, last
//
// Sequence: a clear, an ignored add or a walk of an unknown type goes through S_EMIT, which
//   registers the result. An add steps through head read, tail read and decide/write
//   (S_HEAD, S_ADD), and adds S_LINK when it links behind a pool entry (second pool write).
//   A walk emits its head range from S_WALK after S_HEAD, then each pool range after a
//   registered read of the pool memory (S_WALK_RD); the next transfer is taken once the
//   last range has been emitted.
// Reset: rst_n clears every head valid bit and the pool fill count; memories keep contents.
// Stalls: in_ready is high only while the sequencer idles; a held result in the output
//   register lets the next transfer in, and the sequencer waits on out_ready to emit over it.
`default_nettype none

module per_type_batch_list_builder #(
  parameter int NUM_TYPES    = 8,
  parameter int POOL_ENTRIES = 63,
  parameter int INDEX_BITS   = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [ptbl_pkg::OPCODE_BITS-1:0]  in_opcode,
  input  wire logic [ptbl_pkg::TYPE_BITS-1:0]    in_list_type,
  input  wire logic [INDEX_BITS-1:0]             in_first_index,
  input  wire logic [INDEX_BITS-1:0]             in_instance_count,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic      [ptbl_pkg::STATUS_BITS-1:0]  out_status,
  output logic      [INDEX_BITS-1:0]             out_range_first,
  output logic      [INDEX_BITS-1:0]             out_range_end,
  output logic                                   out_last
);

  import ptbl_pkg::*;

  localparam int IB  = INDEX_BITS;
  // link / slot code: 0 means head (or none), k means pool entry k-1
  localparam int LW  = $clog2(POOL_ENTRIES + 1);
  localparam int TW  = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;
  localparam int PAW = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
  // head word: first, end, link, tail slot
  localparam int HW  = 2 * IB + 2 * LW;
  // pool word: first, end, link
  localparam int PW  = 2 * IB + LW;

  localparam logic [LW-1:0] POOL_LIMIT = LW'(POOL_ENTRIES);
  localparam logic [LW-1:0] LINK_NONE  = '0;
  localparam logic [LW-1:0] LINK_ONE   = LW'(1);

  // ---------------------------------------------------------------- state
  state_t                   state_r, state_nxt;
  logic [NUM_TYPES-1:0]     filled_r;
  logic [LW-1:0]            used_r;

  // latched item
  logic [OPCODE_BITS-1:0]   op_r;
  logic [TW-1:0]            tidx_r;
  logic [IB-1:0]            first_r;
  logic [IB-1:0]            count_r;
  logic [STATUS_BITS-1:0]   stat_r;

  // head copy of the addressed type
  logic                     hd_hit_r;
  logic [IB-1:0]            hd_first_r;
  logic [IB-1:0]            hd_end_r;
  logic [LW-1:0]            hd_link_r;
  logic [LW-1:0]            hd_tail_r;

  // walk cursor
  logic [IB-1:0]            cur_first_r;
  logic [IB-1:0]            cur_end_r;
  logic [LW-1:0]            cur_link_r;
  logic [WALK_CNT_BITS-1:0] walk_cnt_r;

  // output register
  logic                     out_valid_r;
  logic [STATUS_BITS-1:0]   out_status_r;
  logic [IB-1:0]            out_first_r;
  logic [IB-1:0]            out_end_r;
  logic                     out_last_r;

  // ---------------------------------------------------------------- memories
  logic          head_we, head_re;
  logic [TW-1:0] head_raddr;
  logic [HW-1:0] head_wdata, head_rdata;

  logic           pool_we, pool_re;
  logic [PAW-1:0] pool_waddr, pool_raddr;
  logic [PW-1:0]  pool_wdata, pool_rdata;

  ptbl_ram #(.WIDTH(HW), .DEPTH(NUM_TYPES), .AW(TW)) u_head_ram (
    .clk     (clk),
    .wr_en   (head_we),
    .wr_addr (tidx_r),
    .wr_data (head_wdata),
    .rd_en   (head_re),
    .rd_addr (head_raddr),
    .rd_data (head_rdata)
  );

  ptbl_ram #(.WIDTH(PW), .DEPTH(POOL_ENTRIES), .AW(PAW)) u_pool_ram (
    .clk     (clk),
    .wr_en   (pool_we),
    .wr_addr (pool_waddr),
    .wr_data (pool_wdata),
    .rd_en   (pool_re),
    .rd_addr (pool_raddr),
    .rd_data (pool_rdata)
  );

  // ---------------------------------------------------------------- decode
  logic                     in_xfer;
  logic [TYPE_EXT_BITS-1:0] type_ext;
  logic                     type_ok;
  logic                     out_free;

  assign in_xfer  = in_valid && in_ready;
  assign type_ext = {{(TYPE_EXT_BITS - TYPE_BITS){1'b0}}, in_list_type};
  assign type_ok  = type_ext < TYPE_EXT_BITS'(NUM_TYPES);
  assign out_free = !out_valid_r || out_ready;

  // head word as read; an empty head reads as all zero
  logic          rd_hit;
  logic [IB-1:0] rd_h_first, rd_h_end;
  logic [LW-1:0] rd_h_link, rd_h_tail;

  assign rd_hit = filled_r[tidx_r];
  assign {rd_h_first, rd_h_end, rd_h_link, rd_h_tail} = rd_hit ? head_rdata : '0;

  logic [IB-1:0] p_first, p_end;
  logic [LW-1:0] p_link;

  assign {p_first, p_end, p_link} = pool_rdata;

  // shared adder and compare: a tail extend only happens when tail end equals
  // first, so first + count serves every add path; an end past the top index
  // shows up as a carry out
  logic [IB:0]   sum_w;
  logic [IB-1:0] sum;
  logic          ovf;
  logic [IB-1:0] tail_end;
  logic          tail_match;
  logic [LW-1:0] used_inc;

  assign sum_w      = {1'b0, first_r} + {1'b0, count_r};
  assign sum        = sum_w[IB-1:0];
  assign ovf        = sum_w[IB];
  assign tail_end   = (hd_tail_r == LINK_NONE) ? hd_end_r : p_end;
  assign tail_match = tail_end == first_r;
  assign used_inc   = used_r + LINK_ONE;

  logic [LW-1:0] tail_m1, cur_link_m1, rd_tail_m1;

  assign tail_m1     = hd_tail_r - LINK_ONE;
  assign cur_link_m1 = cur_link_r - LINK_ONE;
  assign rd_tail_m1  = rd_h_tail - LINK_ONE;

  logic walk_end;

  assign walk_end = (cur_link_r == LINK_NONE) || (cur_link_r > POOL_LIMIT) ||
                    (walk_cnt_r == WALK_CNT_BITS'(MAX_RESULTS - 1));

  // ---------------------------------------------------------------- datapath control
  logic                   emit;
  logic [STATUS_BITS-1:0] emit_status;
  logic [IB-1:0]          emit_first, emit_end;
  logic                   emit_last;
  logic                   set_filled;
  logic                   bump_used;
  logic                   need_link;

  always_comb begin
    head_re     = 1'b0;
    head_raddr  = type_ext[TW-1:0];
    head_we     = 1'b0;
    head_wdata  = {hd_first_r, hd_end_r, hd_link_r, hd_tail_r};
    pool_re     = 1'b0;
    pool_raddr  = tail_m1[PAW-1:0];
    pool_we     = 1'b0;
    pool_waddr  = used_r[PAW-1:0];
    pool_wdata  = {first_r, sum, LINK_NONE};
    emit        = 1'b0;
    emit_status = stat_r;
    emit_first  = '0;
    emit_end    = '0;
    emit_last   = 1'b1;
    set_filled  = 1'b0;
    bump_used   = 1'b0;
    need_link   = 1'b0;
    case (state_r)
      S_IDLE: begin
        head_re = in_xfer;
      end
      S_HEAD: begin
        // fetch the tail entry when the tail sits in the pool
        pool_re = (op_r == OP_ADD) && rd_hit && (rd_h_tail != LINK_NONE);
        pool_raddr = rd_tail_m1[PAW-1:0];
      end
      S_ADD: begin
        emit = out_free;
        if (!hd_hit_r) begin
          if (ovf) begin
            emit_status = ST_RANGE_OVERFLOW;
          end else begin
            emit_status = ST_HEAD_FILLED;
            head_we     = out_free;
            head_wdata  = {first_r, sum, LINK_NONE, LINK_NONE};
            set_filled  = out_free;
          end
        end else if (tail_match) begin
          if (ovf) begin
            emit_status = ST_RANGE_OVERFLOW;
          end else begin
            emit_status = ST_TAIL_EXTENDED;
            if (hd_tail_r == LINK_NONE) begin
              head_we    = out_free;
              head_wdata = {hd_first_r, sum, hd_link_r, hd_tail_r};
            end else begin
              pool_we    = out_free;
              pool_waddr = tail_m1[PAW-1:0];
              pool_wdata = {p_first, sum, p_link};
            end
          end
        end else if (ovf) begin
          emit_status = ST_RANGE_OVERFLOW;
        end else if (used_r >= POOL_LIMIT) begin
          emit_status = ST_POOL_FULL;
        end else begin
          emit_status = ST_ENTRY_LINKED;
          pool_we     = out_free;
          head_we     = out_free;
          head_wdata  = {hd_first_r, hd_end_r,
                         (hd_tail_r == LINK_NONE) ? used_inc : hd_link_r, used_inc};
          bump_used   = out_free;
          need_link   = hd_tail_r != LINK_NONE;
        end
      end
      S_LINK: begin
        // hook the new entry behind the old pool tail; used_r already points past it
        pool_we    = 1'b1;
        pool_waddr = tail_m1[PAW-1:0];
        pool_wdata = {p_first, p_end, used_r};
      end
      S_WALK: begin
        emit        = out_free;
        emit_status = ST_RANGE_LISTED;
        emit_first  = cur_first_r;
        emit_end    = cur_end_r;
        emit_last   = walk_end;
        pool_re     = out_free && !walk_end;
        pool_raddr  = cur_link_m1[PAW-1:0];
      end
      S_WALK_RD: begin
      end
      S_EMIT: begin
        emit = out_free;
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          case (in_opcode)
            OP_CLEAR: state_nxt = S_EMIT;
            OP_ADD: begin
              if (in_instance_count == '0 || !type_ok) begin
                state_nxt = S_EMIT;
              end else begin
                state_nxt = S_HEAD;
              end
            end
            OP_WALK: state_nxt = type_ok ? S_HEAD : S_EMIT;
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_HEAD:    state_nxt = (op_r == OP_ADD) ? S_ADD : S_WALK;
      S_ADD: begin
        if (out_free) begin
          state_nxt = need_link ? S_LINK : S_IDLE;
        end
      end
      S_LINK:    state_nxt = S_IDLE;
      S_WALK: begin
        if (out_free) begin
          state_nxt = walk_end ? S_IDLE : S_WALK_RD;
        end
      end
      S_WALK_RD: state_nxt = S_WALK;
      S_EMIT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default:   state_nxt = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      filled_r    <= '0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_xfer && in_opcode == OP_CLEAR) begin
        filled_r <= '0;
        used_r   <= '0;
      end else begin
        if (set_filled) begin
          filled_r[tidx_r] <= 1'b1;
        end
        if (bump_used) begin
          used_r <= used_inc;
        end
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_r    <= in_opcode;
      tidx_r  <= type_ext[TW-1:0];
      first_r <= in_first_index;
      count_r <= in_instance_count;
      case (in_opcode)
        OP_CLEAR: stat_r <= ST_CLEARED;
        OP_ADD:   stat_r <= ST_ZERO_IGNORED;
        default:  stat_r <= ST_RANGE_LISTED;
      endcase
    end
    if (state_r == S_HEAD) begin
      hd_hit_r    <= rd_hit;
      hd_first_r  <= rd_h_first;
      hd_end_r    <= rd_h_end;
      hd_link_r   <= rd_h_link;
      hd_tail_r   <= rd_h_tail;
      cur_first_r <= rd_h_first;
      cur_end_r   <= rd_h_end;
      cur_link_r  <= rd_h_link;
      walk_cnt_r  <= '0;
    end
    if (pool_re && state_r == S_WALK) begin
      walk_cnt_r <= walk_cnt_r + WALK_CNT_BITS'(1);
    end
    // advance the cursor to the pool entry just read
    if (state_r == S_WALK_RD) begin
      cur_first_r <= p_first;
      cur_end_r   <= p_end;
      cur_link_r  <= p_link;
    end
    if (emit) begin
      out_status_r <= emit_status;
      out_first_r  <= emit_first;
      out_end_r    <= emit_end;
      out_last_r   <= emit_last;
    end
  end

  assign in_ready        = state_r == S_IDLE;
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_range_first = out_first_r;
  assign out_range_end   = out_end_r;
  assign out_last        = out_last_r;

  // ---------------------------------------------------------------- assertions
  a_used_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= POOL_LIMIT)
    else $error("pool fill count passed the pool size");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> (!out_valid_r || out_ready))
    else $error("held result overwritten before its transfer");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_opcode == OP_CLEAR) |=> (filled_r == '0 && used_r == '0))
    else $error("clear left a list or the pool occupied");

  a_pool_write_state: assert property (@(posedge clk) disable iff (!rst_n)
    pool_we |-> (state_r == S_ADD || state_r == S_LINK))
    else $error("pool written outside an add");

  a_link_follows_add: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LINK) |-> ($past(state_r) == S_ADD && $past(bump_used)))
    else $error("link write without a new pool entry");

endmodule

`default_nettype wire

@@ rtl/core/ptbl_ram.sv @@
`default_nettype none

module ptbl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire
